// ===== src/cpu_alu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_pkg
// Operation codes, status bit positions, pipeline payload and flag helpers
// used by the execute unit.
// ----------------------------------------------------------------------------
package cpu_alu_pkg;

	localparam int WORD_W   = 16;
	localparam int DIV_BITS = 2;
	localparam int DIV_STGS = WORD_W / DIV_BITS;
	localparam int DEPTH    = DIV_STGS + 1;

	localparam int LGT_BIT = 15;
	localparam int AGT_BIT = 14;
	localparam int EQ_BIT  = 13;
	localparam int C_BIT   = 12;
	localparam int OV_BIT  = 11;
	localparam int OP_BIT  = 10;

	typedef enum logic [5:0] {
		OP_A    = 6'd0,  OP_AB   = 6'd1,  OP_S    = 6'd2,  OP_SB   = 6'd3,
		OP_C    = 6'd4,  OP_CB   = 6'd5,  OP_MOV  = 6'd6,  OP_MOVB = 6'd7,
		OP_SOC  = 6'd8,  OP_SOCB = 6'd9,  OP_SZC  = 6'd10, OP_SZCB = 6'd11,
		OP_XOR  = 6'd12, OP_COC  = 6'd13, OP_CZC  = 6'd14, OP_MPY  = 6'd15,
		OP_DIV  = 6'd16, OP_LI   = 6'd17, OP_AI   = 6'd18, OP_ANDI = 6'd19,
		OP_ORI  = 6'd20, OP_CI   = 6'd21, OP_STST = 6'd22, OP_CLR  = 6'd23,
		OP_SETO = 6'd24, OP_NEG  = 6'd25, OP_INV  = 6'd26, OP_INC  = 6'd27,
		OP_INCT = 6'd28, OP_DEC  = 6'd29, OP_DECT = 6'd30, OP_SWPB = 6'd31,
		OP_ABS  = 6'd32, OP_SRA  = 6'd33, OP_SRL  = 6'd34, OP_SLA  = 6'd35,
		OP_SRC  = 6'd36, OP_JMP  = 6'd37, OP_JLT  = 6'd38, OP_JLE  = 6'd39,
		OP_JEQ  = 6'd40, OP_JHE  = 6'd41, OP_JGT  = 6'd42, OP_JNE  = 6'd43,
		OP_JNC  = 6'd44, OP_JOC  = 6'd45, OP_JNO  = 6'd46, OP_JL   = 6'd47,
		OP_JH   = 6'd48
	} op_t;

	typedef struct packed {
		logic [15:0] result;
		logic [15:0] result_second;
		logic        write_result;
		logic        write_second;
		logic        byte_write;
		logic [15:0] status_out;
		logic        take_jump;
		logic [15:0] next_pc;
		logic        div_go;
		logic [15:0] divisor;
		logic [15:0] rem;
		logic [15:0] quo;
	} pipe_t;

	function automatic logic [15:0] put(logic [15:0] st, int idx, logic c);
		logic [15:0] o;
		o      = st;
		o[idx] = c;
		return o;
	endfunction

	function automatic logic [15:0] cmp_word(logic [15:0] st, logic [15:0] a,
			logic [15:0] b);
		logic [15:0] o;
		o = put(st, EQ_BIT, a == b);
		o = put(o, LGT_BIT, a > b);
		o = put(o, AGT_BIT, (a ^ 16'h8000) > (b ^ 16'h8000));
		return o;
	endfunction

	function automatic logic [15:0] cmp_byte(logic [15:0] st, logic [7:0] a,
			logic [7:0] b);
		logic [15:0] o;
		o = put(st, EQ_BIT, a == b);
		o = put(o, LGT_BIT, a > b);
		o = put(o, AGT_BIT, (a ^ 8'h80) > (b ^ 8'h80));
		return o;
	endfunction

	function automatic logic [15:0] parity(logic [15:0] st, logic [7:0] v);
		return put(st, OP_BIT, ^v);
	endfunction

	function automatic pipe_t div_step(pipe_t p);
		pipe_t       o;
		logic [16:0] r;
		o = p;
		for (int i = 0; i < DIV_BITS; i++) begin
			r     = {o.rem, o.quo[15]};
			o.quo = {o.quo[14:0], 1'b0};
			if (r >= {1'b0, o.divisor}) begin
				r        = r - {1'b0, o.divisor};
				o.quo[0] = 1'b1;
			end
			o.rem = r[15:0];
		end
		return o;
	endfunction

endpackage

// ===== src/alu_in_if.sv =====
// ----------------------------------------------------------------------------
// alu_in_if
// Operand channel of the execute unit: valid, ready and one instruction.
// ----------------------------------------------------------------------------
interface alu_in_if;
	logic              valid;
	logic              ready;
	logic [5:0]        mode;
	logic [15:0]       src_data;
	logic [15:0]       dst_data;
	logic [15:0]       dst_low_word;
	logic [3:0]        shift_count;
	logic [3:0]        reg0_count;
	logic              odd_address;
	logic [15:0]       status_in;
	logic [15:0]       pc_value;
	logic signed [7:0] jump_offset;

	modport source (output valid, mode, src_data, dst_data, dst_low_word, shift_count,
		reg0_count, odd_address, status_in, pc_value, jump_offset, input ready);
	modport sink (input valid, mode, src_data, dst_data, dst_low_word, shift_count,
		reg0_count, odd_address, status_in, pc_value, jump_offset, output ready);
endinterface

// ===== src/alu_out_if.sv =====
// ----------------------------------------------------------------------------
// alu_out_if
// Result channel of the execute unit: valid, ready and one result.
// ----------------------------------------------------------------------------
interface alu_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result;
	logic [15:0] result_second;
	logic        write_result;
	logic        write_second;
	logic        byte_write;
	logic [15:0] status_out;
	logic        take_jump;
	logic [15:0] next_pc;

	modport source (output valid, result, result_second, write_result, write_second,
		byte_write, status_out, take_jump, next_pc, input ready);
	modport sink (input valid, result, result_second, write_result, write_second,
		byte_write, status_out, take_jump, next_pc, output ready);
endinterface

// ===== src/cpu_alu_and_status_flags.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_and_status_flags
// Pipelined execute unit: word/byte ALU, multiply, 32/16 divide, shifts,
// status flags and jump resolution.
//
//   channel    dir   payload
//   operands   in    mode, src/dst/low words, counts, status, pc, offset
//   results    out   result words, strobes, status, jump, next pc
//
// One instruction enters per cycle while the pipe advances.
// Stage one does all ALU, multiply, shift and jump work; the following
// eight stages each retire two quotient bits of the divide.
// The whole pipe advances together while the last stage is empty or taken.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module cpu_alu_and_status_flags
	import cpu_alu_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	alu_in_if.sink operands,
	alu_out_if.source results
);

	pipe_t stage_s [DEPTH];
	logic  valid_s [DEPTH];
	pipe_t head;
	logic  advance;

	assign advance        = !valid_s[DEPTH-1] || results.ready;
	assign operands.ready = advance;

	always_comb begin
		logic [15:0] s, d, st, r, r2, tgt;
		logic [7:0]  sb, db, rb;
		logic [16:0] t;
		logic [8:0]  tb;
		logic [4:0]  cnt;
		logic [31:0] x, prod;
		logic        wr, w2, bw, tj, go;
		s    = operands.src_data;
		d    = operands.dst_data;
		sb   = s[7:0];
		db   = d[7:0];
		st   = operands.status_in;
		r    = '0;
		r2   = '0;
		rb   = '0;
		t    = '0;
		tb   = '0;
		x    = '0;
		wr   = 1'b0;
		w2   = 1'b0;
		bw   = 1'b0;
		tj   = 1'b0;
		go   = 1'b0;
		prod = {16'h0, d} * {16'h0, s};
		cnt  = (operands.shift_count != 4'd0) ? {1'b0, operands.shift_count} :
			(operands.reg0_count != 4'd0) ? {1'b0, operands.reg0_count} : 5'd16;
		case (op_t'(operands.mode))
			OP_A, OP_AI: begin
				t  = {1'b0, d} + {1'b0, s};
				r  = t[15:0];
				st = put(st, OV_BIT, !(s[15] ^ d[15]) && (r[15] ^ d[15]));
				st = put(st, C_BIT, t[16]);
				st = cmp_word(st, r, 16'h0);
				wr = 1'b1;
			end
			OP_AB: begin
				tb = {1'b0, db} + {1'b0, sb};
				rb = tb[7:0];
				st = put(st, OV_BIT, !(sb[7] ^ db[7]) && (rb[7] ^ db[7]));
				st = put(st, C_BIT, tb[8]);
				st = parity(cmp_byte(st, rb, 8'h0), rb);
				r  = {8'h0, rb};
				wr = 1'b1;
				bw = 1'b1;
			end
			OP_S: begin
				r  = d - s;
				st = put(st, OV_BIT, (s[15] ^ d[15]) && (r[15] ^ d[15]));
				st = put(st, C_BIT, d >= s);
				st = cmp_word(st, r, 16'h0);
				wr = 1'b1;
			end
			OP_SB: begin
				rb = db - sb;
				st = put(st, OV_BIT, (sb[7] ^ db[7]) && (rb[7] ^ db[7]));
				st = put(st, C_BIT, db >= sb);
				st = parity(cmp_byte(st, rb, 8'h0), rb);
				r  = {8'h0, rb};
				wr = 1'b1;
				bw = 1'b1;
			end
			OP_C:  st = cmp_word(st, s, d);
			OP_CB: st = parity(cmp_byte(st, sb, db), sb);
			OP_MOV, OP_LI: begin
				r  = s;
				st = cmp_word(st, r, 16'h0);
				wr = 1'b1;
			end
			OP_MOVB, OP_SOCB, OP_SZCB: begin
				rb = (op_t'(operands.mode) == OP_MOVB) ? sb :
					(op_t'(operands.mode) == OP_SOCB) ? (db | sb) : (db & ~sb);
				st = parity(cmp_byte(st, rb, 8'h0), rb);
				r  = {8'h0, rb};
				wr = 1'b1;
				bw = 1'b1;
			end
			OP_SOC, OP_ORI, OP_SZC, OP_XOR, OP_ANDI, OP_INV, OP_SWPB: begin
				case (op_t'(operands.mode))
					OP_SOC, OP_ORI: r = d | s;
					OP_SZC:         r = d & ~s;
					OP_XOR:         r = d ^ s;
					OP_ANDI:        r = d & s;
					OP_INV:         r = ~d;
					default:        r = {d[7:0], d[15:8]};
				endcase
				st = cmp_word(st, r, 16'h0);
				wr = 1'b1;
			end
			OP_COC: st = cmp_word(st, s & d, s);
			OP_CZC: st = cmp_word(st, s & ~d, s);
			OP_MPY: begin
				r  = prod[31:16];
				r2 = prod[15:0];
				wr = 1'b1;
				w2 = 1'b1;
			end
			OP_DIV: begin
				go = s > d;
				st = put(st, OV_BIT, !go);
				wr = go;
				w2 = go;
			end
			OP_CI:   st = cmp_word(st, d, s);
			OP_STST: begin
				r  = st;
				wr = 1'b1;
			end
			OP_CLR:  wr = 1'b1;
			OP_SETO: begin
				r  = 16'hFFFF;
				wr = 1'b1;
			end
			OP_NEG: begin
				st = put(st, C_BIT, d == 16'h8000);
				st = put(st, OV_BIT, d[15]);
				r  = -d;
				st = cmp_word(st, r, 16'h0);
				wr = 1'b1;
			end
			OP_INC, OP_INCT, OP_DEC, OP_DECT: begin
				case (op_t'(operands.mode))
					OP_INC: begin
						r  = d + 16'd1;
						st = put(st, C_BIT, d == 16'hFFFF);
					end
					OP_INCT: begin
						r  = d + 16'd2;
						st = put(st, C_BIT, d[15:1] == 15'h7FFF);
					end
					OP_DEC: begin
						r  = d - 16'd1;
						st = put(st, C_BIT, d >= 16'd1);
					end
					default: begin
						r  = d - 16'd2;
						st = put(st, C_BIT, d >= 16'd2);
					end
				endcase
				if (op_t'(operands.mode) == OP_INC || op_t'(operands.mode) == OP_INCT)
					st = put(st, OV_BIT, !d[15] && r[15]);
				else
					st = put(st, OV_BIT, d[15] && !r[15]);
				if (operands.odd_address && (op_t'(operands.mode) == OP_INCT ||
						op_t'(operands.mode) == OP_DECT)) begin
					r  = {8'h0, r[7:0]};
					st = cmp_byte(st, r[7:0], 8'h0);
					bw = 1'b1;
				end else begin
					st = cmp_word(st, r, 16'h0);
				end
				wr = 1'b1;
			end
			OP_ABS: begin
				st = put(st, C_BIT, d == 16'h8000);
				st = put(st, OV_BIT, d[15]);
				st = put(st, AGT_BIT, d != 16'h0 && !d[15]);
				r  = d[15] ? -d : d;
				st = put(st, EQ_BIT, r == 16'h0);
				st = put(st, LGT_BIT, r != 16'h0);
				wr = 1'b1;
			end
			OP_SRA, OP_SRL, OP_SRC: begin
				if (op_t'(operands.mode) == OP_SRA)
					x = $unsigned($signed({d, 16'h0}) >>> cnt);
				else if (op_t'(operands.mode) == OP_SRC)
					x = {d, d} >> cnt;
				else
					x = {d, 16'h0} >> cnt;
				st = put(st, C_BIT, x[15]);
				r  = (op_t'(operands.mode) == OP_SRC) ? x[15:0] : x[31:16];
				st = cmp_word(st, r, 16'h0);
				wr = 1'b1;
			end
			OP_SLA: begin
				x  = {16'h0, d} << cnt;
				st = put(st, C_BIT, x[16]);
				st = put(st, OV_BIT, x[15] != d[15]);
				r  = x[15:0];
				st = cmp_word(st, r, 16'h0);
				wr = 1'b1;
			end
			OP_JMP: tj = 1'b1;
			OP_JLT: tj = !st[AGT_BIT] && !st[EQ_BIT];
			OP_JLE: tj = st[EQ_BIT] || !st[LGT_BIT];
			OP_JEQ: tj = st[EQ_BIT];
			OP_JHE: tj = st[LGT_BIT] || st[EQ_BIT];
			OP_JGT: tj = st[AGT_BIT] && !st[EQ_BIT];
			OP_JNE: tj = !st[EQ_BIT];
			OP_JNC: tj = !st[C_BIT];
			OP_JOC: tj = st[C_BIT];
			OP_JNO: tj = !st[OV_BIT];
			OP_JL:  tj = !st[LGT_BIT] && !st[EQ_BIT];
			OP_JH:  tj = st[LGT_BIT] && !st[EQ_BIT];
			default: ;
		endcase
		tgt                = {{7{operands.jump_offset[7]}}, operands.jump_offset, 1'b0};
		head.result        = r;
		head.result_second = r2;
		head.write_result  = wr;
		head.write_second  = w2;
		head.byte_write    = bw;
		head.status_out    = st;
		head.take_jump     = tj;
		head.next_pc       = tj ? operands.pc_value + tgt : operands.pc_value;
		head.div_go        = go;
		head.divisor       = s;
		head.rem           = d;
		head.quo           = operands.dst_low_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				valid_s[i] <= 1'b0;
		end else if (advance) begin
			valid_s[0] <= operands.valid;
			for (int i = 1; i < DEPTH; i++)
				valid_s[i] <= valid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stage_s[0] <= head;
			for (int i = 1; i < DEPTH; i++)
				stage_s[i] <= div_step(stage_s[i-1]);
		end
	end

	assign results.valid         = valid_s[DEPTH-1];
	assign results.result        = stage_s[DEPTH-1].div_go ? stage_s[DEPTH-1].quo :
		stage_s[DEPTH-1].result;
	assign results.result_second = stage_s[DEPTH-1].div_go ? stage_s[DEPTH-1].rem :
		stage_s[DEPTH-1].result_second;
	assign results.write_result  = stage_s[DEPTH-1].write_result;
	assign results.write_second  = stage_s[DEPTH-1].write_second;
	assign results.byte_write    = stage_s[DEPTH-1].byte_write;
	assign results.status_out    = stage_s[DEPTH-1].status_out;
	assign results.take_jump     = stage_s[DEPTH-1].take_jump;
	assign results.next_pc       = stage_s[DEPTH-1].next_pc;

`ifndef SYNTH
	a_second_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.write_second |-> results.write_result)
		else $error("second word stored without main word");
	a_byte_single: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.byte_write |-> results.write_result && !results.write_second)
		else $error("byte store with bad strobes");
	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.write_result |-> results.result == 16'h0)
		else $error("result nonzero without store");
	a_no_jump_pc: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.take_jump |-> !results.write_result)
		else $error("jump with a store");
`endif

endmodule
